// ----- hdl/ast_pkg.sv -----
// Shared types, codes and constants of the alarm slot table.
package ast_pkg;

    localparam int SLOTS_DEF  = 8;
    localparam int STAMP_W    = 40;
    localparam int HANDLER_W  = 8;
    localparam int SLOT_W     = 3;
    localparam int RESULT_CAP = 8;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADDED   = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_FIRED   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef struct packed {
        logic                 cmd;
        logic [STAMP_W-1:0]   stamp;
        logic [HANDLER_W-1:0] handler_id;
    } req_t;

    typedef struct packed {
        kind_t                kind;
        logic [SLOT_W-1:0]    slot;
        logic [HANDLER_W-1:0] fired_handler;
        logic                 last;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // take a new request, restart the scan
        logic advance;  // step to the next slot
        logic take;     // act on the current slot (store or fire)
        logic emit;     // write the closing result
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_add;
        logic hit;
        logic last_idx;
        logic cap_reached;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/alarm_slot_table_core.sv -----
// Top level of the alarm slot table: sequencer plus slot datapath.
// Scan: a request scans the slots one per cycle unless a fired result waits for the
// output register; an add stops at the first free slot, else drops at the last one,
// and a check stops at the last slot (earlier once eight alarms have fired); the
// final result waits on output stalls. Requests are taken one at a time, in the idle
// state entered once the final result is written (single due-time comparator).
// Reset: rst_n clears every slot's active bit at once; no clearing pass.
module alarm_slot_table_core #(
    parameter int SLOTS = ast_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ast_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ast_pkg::rsp_t rsp
);

    // Command and status between the sequencer and the datapath.
    ast_pkg::dp_cmd_t    dp_cmd;
    ast_pkg::dp_status_t dp_status;

    // Sequencer: accept a request in idle, walk the slots, then close the
    // request with its final result. Hold the walk while a fired result
    // waits for the output register.
    ast_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // Datapath: slot memories, active bits, the due-time compare, one
    // pending result (so the last flag can be set on the final fire) and
    // the output register that parts the two channels.
    ast_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule

// ----- hdl/ast_ctrl.sv -----
// Sequencer of the alarm slot table: slot scan and result hand-off.
module ast_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ast_pkg::dp_status_t status,
    output ast_pkg::dp_cmd_t    cmd
);

    ast_pkg::state_t state_reg;
    ast_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ast_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ast_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ast_pkg::ST_SCAN;
                end
            end
            ast_pkg::ST_SCAN:
            begin
                if (status.hit)
                begin
                    if (status.is_add)
                    begin
                        state_next = ast_pkg::ST_FINISH;
                    end
                    else if (!status.pend_valid || status.out_free)
                    begin
                        if (status.cap_reached || status.last_idx)
                        begin
                            state_next = ast_pkg::ST_FINISH;
                        end
                    end
                end
                else if (status.last_idx)
                begin
                    state_next = ast_pkg::ST_FINISH;
                end
            end
            ast_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ast_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ast_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ast_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ast_pkg::ST_SCAN:
            begin
                if (status.hit)
                begin
                    if (status.is_add)
                    begin
                        cmd.take = 1'b1;
                    end
                    else if (!status.pend_valid || status.out_free)
                    begin
                        cmd.take    = 1'b1;
                        cmd.advance = !(status.cap_reached || status.last_idx);
                    end
                end
                else
                begin
                    cmd.advance = !status.last_idx;
                end
            end
            ast_pkg::ST_FINISH:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/ast_dp.sv -----
// Datapath of the alarm slot table: slot storage, compare and result registers.
module ast_dp #(
    parameter int SLOTS = ast_pkg::SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ast_pkg::req_t       req,
    input  ast_pkg::dp_cmd_t    cmd,
    output ast_pkg::dp_status_t status,
    output ast_pkg::rsp_t       rsp,
    output logic                rsp_valid,
    input  logic                rsp_stall
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ast_pkg::STAMP_W-1:0]   due_mem     [SLOTS];
    logic [ast_pkg::HANDLER_W-1:0] handler_mem [SLOTS];

    logic [SLOTS-1:0]              active_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic                          cmd_reg;
    logic [ast_pkg::STAMP_W-1:0]   stamp_reg;
    logic [ast_pkg::HANDLER_W-1:0] handler_reg;
    logic [ast_pkg::CNT_W-1:0]     fire_cnt_reg;
    logic [ast_pkg::STAMP_W-1:0]   rd_due_reg;
    logic [ast_pkg::HANDLER_W-1:0] rd_handler_reg;
    logic                          pend_valid_reg;
    ast_pkg::rsp_t                 pend_reg;
    ast_pkg::rsp_t                 pend_next;
    ast_pkg::rsp_t                 rsp_reg;
    ast_pkg::rsp_t                 rsp_next;
    logic                          rsp_valid_reg;
    logic                          is_add;
    logic                          out_free;
    logic                          push_pend;

    assign is_add   = (cmd_reg == ast_pkg::CMD_ADD);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    // A fire while a result is pending moves the pending one out, not last.
    assign push_pend = cmd.take && !is_add && pend_valid_reg;

    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        pend_next      = '0;
        pend_next.slot = ast_pkg::SLOT_W'(idx_reg);
        if (is_add)
        begin
            pend_next.kind = ast_pkg::KIND_ADDED;
        end
        else
        begin
            pend_next.kind          = ast_pkg::KIND_FIRED;
            pend_next.fired_handler = rd_handler_reg;
        end
    end

    // Result to load into the output register: the pending one, or the
    // closing drop / nothing-fired result when none is pending.
    always_comb
    begin
        rsp_next = pend_reg;
        if (push_pend)
        begin
            rsp_next.last = 1'b0;
        end
        else if (pend_valid_reg)
        begin
            rsp_next.last = 1'b1;
        end
        else
        begin
            rsp_next      = '0;
            rsp_next.kind = is_add ? ast_pkg::KIND_DROPPED : ast_pkg::KIND_NONE;
            rsp_next.last = 1'b1;
        end
    end

    always_comb
    begin
        status.is_add      = is_add;
        status.hit         = is_add ? !active_reg[idx_reg]
                                    : (active_reg[idx_reg] && (rd_due_reg <= stamp_reg));
        status.last_idx    = (idx_reg == IDX_W'(SLOTS - 1));
        status.cap_reached = (fire_cnt_reg == ast_pkg::CNT_W'(ast_pkg::RESULT_CAP - 1));
        status.pend_valid  = pend_valid_reg;
        status.out_free    = out_free;
    end

    // Slot memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.take && is_add)
        begin
            due_mem[idx_reg]     <= stamp_reg;
            handler_mem[idx_reg] <= handler_reg;
        end
        rd_due_reg     <= due_mem[idx_next];
        rd_handler_reg <= handler_mem[idx_next];
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= req.cmd;
            stamp_reg   <= req.stamp;
            handler_reg <= req.handler_id;
        end
        if (cmd.take)
        begin
            pend_reg <= pend_next;
        end
        if (push_pend || cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            idx_reg        <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                fire_cnt_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.take)
            begin
                pend_valid_reg <= 1'b1;
                if (!is_add)
                begin
                    fire_cnt_reg <= fire_cnt_reg + ast_pkg::CNT_W'(1);
                end
            end
            else if (cmd.emit)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.take)
            begin
                active_reg[idx_reg] <= is_add;
            end

            if (push_pend || cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
